// ===== rtl/dhcp_option_parser_assert.svh =====
// assertion macros for the dhcp option parser
// used by the top level; relies on clk and rst in the including scope
`ifndef DHCP_OPTION_PARSER_ASSERT_SVH
`define DHCP_OPTION_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DHCPOP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dhcp option parser check failed");

// next-cycle implication, disabled during reset
`define DHCPOP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dhcp option parser check failed");

`endif

// ===== rtl/dhcpop_pkg.sv =====
// shared types and constants of the dhcp option parser
// no dependencies
`default_nettype none

package dhcpop_pkg;

  // option codes
  localparam logic [7:0] OPT_PAD       = 8'h00;
  localparam logic [7:0] OPT_END       = 8'hFF;
  localparam logic [7:0] OPT_MASK      = 8'd1;
  localparam logic [7:0] OPT_ROUTER    = 8'd3;
  localparam logic [7:0] OPT_DNS       = 8'd6;
  localparam logic [7:0] OPT_NTP       = 8'd42;
  localparam logic [7:0] OPT_TYPE      = 8'd53;
  localparam logic [7:0] OPT_SERVER_ID = 8'd54;

  // value bytes kept per record
  localparam logic [2:0] VALUE_BYTES = 3'd4;

  typedef enum logic [3:0] {
    PH_CODE = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_VAL  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  cur_code;
    logic [7:0]  bytes_left;
    logic [2:0]  value_pos;
    logic [31:0] value_shift;
    logic [7:0]  type_reg;
    logic [31:0] mask_reg;
    logic [31:0] router_reg;
    logic [31:0] dns_reg;
    logic [31:0] ntp_reg;
    logic [31:0] server_reg;
    logic        server_flag;
    logic        ended_flag;
  } state_t;

  typedef struct packed {
    logic [7:0]  msg_type;
    logic [31:0] subnet_mask;
    logic [31:0] router_addr;
    logic [31:0] dns_addr;
    logic [31:0] ntp_addr;
    logic [31:0] server_ident;
    logic        server_found;
    logic        cut_short;
    logic        end_seen;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:       PH_CODE,
    cur_code:    8'h00,
    bytes_left:  8'h00,
    value_pos:   3'd0,
    value_shift: 32'h0,
    type_reg:    8'h00,
    mask_reg:    32'h0,
    router_reg:  32'h0,
    dns_reg:     32'h0,
    ntp_reg:     32'h0,
    server_reg:  32'h0,
    server_flag: 1'b0,
    ended_flag:  1'b0
  };

endpackage

`default_nettype wire

// ===== rtl/dhcpop_in_if.sv =====
// byte channel into the dhcp option parser
// no dependencies
`default_nettype none

interface dhcpop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opt_byte;
  logic       last;

  modport source (output valid, output opt_byte, output last, input ready);
  modport sink   (input valid, input opt_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/dhcpop_out_if.sv =====
// result channel out of the dhcp option parser
// no dependencies
`default_nettype none

interface dhcpop_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  msg_type;
  logic [31:0] subnet_mask;
  logic [31:0] router_addr;
  logic [31:0] dns_addr;
  logic [31:0] ntp_addr;
  logic [31:0] server_ident;
  logic        server_found;
  logic        cut_short;
  logic        end_seen;

  modport source (output valid, output msg_type, output subnet_mask, output router_addr,
                  output dns_addr, output ntp_addr, output server_ident,
                  output server_found, output cut_short, output end_seen, input ready);
  modport sink   (input valid, input msg_type, input subnet_mask, input router_addr,
                  input dns_addr, input ntp_addr, input server_ident,
                  input server_found, input cut_short, input end_seen, output ready);
endinterface

`default_nettype wire

// ===== rtl/dhcpop_step.sv =====
// one parse step: next parser state and result fields for one options byte
// depends on dhcpop_pkg
`default_nettype none

module dhcpop_step (
  input  dhcpop_pkg::state_t  cur,
  input  logic [7:0]          opt_byte,
  output dhcpop_pkg::state_t  nxt,
  output dhcpop_pkg::result_t res
);

  // store a finished record value into its option register
  function automatic dhcpop_pkg::state_t commit(input dhcpop_pkg::state_t s);
    dhcpop_pkg::state_t r;
    r = s;
    case (s.cur_code)
      dhcpop_pkg::OPT_TYPE:   r.type_reg   = s.value_shift[31:24];
      dhcpop_pkg::OPT_MASK:   r.mask_reg   = s.value_shift;
      dhcpop_pkg::OPT_ROUTER: r.router_reg = s.value_shift;
      dhcpop_pkg::OPT_DNS:    r.dns_reg    = s.value_shift;
      dhcpop_pkg::OPT_NTP:    r.ntp_reg    = s.value_shift;
      dhcpop_pkg::OPT_SERVER_ID: begin
        if (!s.server_flag) begin
          r.server_reg  = s.value_shift;
          r.server_flag = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  dhcpop_pkg::state_t st;
  logic [31:0]        merged;

  // big-endian placement of a value byte
  always_comb begin
    unique case (cur.value_pos[1:0])
      2'd0: merged = cur.value_shift | {opt_byte, 24'h0};
      2'd1: merged = cur.value_shift | {8'h0, opt_byte, 16'h0};
      2'd2: merged = cur.value_shift | {16'h0, opt_byte, 8'h0};
      2'd3: merged = cur.value_shift | {24'h0, opt_byte};
      default: merged = cur.value_shift;
    endcase
  end

  // record walk
  always_comb begin
    st = cur;
    unique case (cur.phase)
      dhcpop_pkg::PH_CODE: begin
        if (opt_byte == dhcpop_pkg::OPT_END) begin
          st.ended_flag = 1'b1;
          st.phase      = dhcpop_pkg::PH_DONE;
        end else if (opt_byte != dhcpop_pkg::OPT_PAD) begin
          st.cur_code = opt_byte;
          st.phase    = dhcpop_pkg::PH_LEN;
        end
      end
      dhcpop_pkg::PH_LEN: begin
        st.bytes_left  = opt_byte;
        st.value_pos   = 3'd0;
        st.value_shift = 32'h0;
        if (opt_byte == 8'h00) begin
          st       = commit(st);
          st.phase = dhcpop_pkg::PH_CODE;
        end else begin
          st.phase = dhcpop_pkg::PH_VAL;
        end
      end
      dhcpop_pkg::PH_VAL: begin
        // bytes past the fourth are skipped
        if (cur.value_pos < dhcpop_pkg::VALUE_BYTES) begin
          st.value_shift = merged;
          st.value_pos   = cur.value_pos + 3'd1;
        end
        st.bytes_left = cur.bytes_left - 8'd1;
        if (st.bytes_left == 8'h00) begin
          st       = commit(st);
          st.phase = dhcpop_pkg::PH_CODE;
        end
      end
      default: ;
    endcase
  end

  assign nxt = st;

  // result fields as seen after this byte
  always_comb begin
    res.msg_type     = st.type_reg;
    res.subnet_mask  = st.mask_reg;
    res.router_addr  = st.router_reg;
    res.dns_addr     = st.dns_reg;
    res.ntp_addr     = st.ntp_reg;
    res.server_ident = st.server_reg;
    res.server_found = st.server_flag;
    res.cut_short    = (st.phase == dhcpop_pkg::PH_LEN) || (st.phase == dhcpop_pkg::PH_VAL);
    res.end_seen     = st.ended_flag;
  end

endmodule

`default_nettype wire

// ===== rtl/dhcp_option_parser.sv =====
// dhcp option parser top level: input register, parse state, result register
// depends on dhcpop_pkg, dhcpop_in_if, dhcpop_out_if, dhcpop_step
`default_nettype none

// Walks the options area of a received DHCP message, one byte per transfer on
// opts, and gives one transfer on result for the byte marked last, holding the
// message type, subnet mask, router, DNS and NTP addresses, the first server
// identifier, and flags for a cut-off record and a seen end marker; the parser
// then starts over for the next message. Throughput is one byte per clock while
// the input does not stall: each byte is held in the input register, then a
// single parse step updates the state. The last byte passes through the input
// register and then sets the result register, which offers it on result.
// The input stalls only while a last byte waits in the input register and the
// previous result has not yet been taken.
module dhcp_option_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  dhcpop_in_if.sink            opts,
  dhcpop_out_if.source         result
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  dhcpop_pkg::state_t  st;
  dhcpop_pkg::state_t  st_next;
  dhcpop_pkg::result_t res_next;
  dhcpop_pkg::result_t res;
  logic                res_valid;

  logic out_free;
  logic s1_fire;
  logic s1_adv;

  assign out_free = !res_valid || result.ready;
  assign s1_adv   = !s1_last || out_free;
  assign s1_fire  = s1_valid && s1_adv;
  assign opts.ready = !s1_valid || s1_adv;

  // capture incoming byte
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (opts.ready) begin
      s1_valid <= opts.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (opts.ready && opts.valid) begin
      s1_byte <= opts.opt_byte;
      s1_last <= opts.last;
    end
  end

  // parse step
  dhcpop_step u_step (
    .cur      (st),
    .opt_byte (s1_byte),
    .nxt      (st_next),
    .res      (res_next)
  );

  // parser state, cleared after each message
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= dhcpop_pkg::STATE_RESET;
    end else if (s1_fire) begin
      st <= s1_last ? dhcpop_pkg::STATE_RESET : st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      res <= res_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.msg_type     = res.msg_type;
  assign result.subnet_mask  = res.subnet_mask;
  assign result.router_addr  = res.router_addr;
  assign result.dns_addr     = res.dns_addr;
  assign result.ntp_addr     = res.ntp_addr;
  assign result.server_ident = res.server_ident;
  assign result.server_found = res.server_found;
  assign result.cut_short    = res.cut_short;
  assign result.end_seen     = res.end_seen;

  `include "dhcp_option_parser_assert.svh"

  // a finished message leaves the parser clean
  `DHCPOP_ASSERT_NEXT(a_clear_after_last, s1_fire && s1_last, (st.phase == dhcpop_pkg::PH_CODE) && !st.ended_flag && !st.server_flag)
  // the after-end phase is only reached through an end marker
  `DHCPOP_ASSERT_IMP(a_done_has_end, st.phase == dhcpop_pkg::PH_DONE, st.ended_flag)
  // value position saturates at four bytes
  `DHCPOP_ASSERT_IMP(a_pos_bound, 1'b1, st.value_pos <= dhcpop_pkg::VALUE_BYTES)
  // no server identifier without its found flag
  `DHCPOP_ASSERT_IMP(a_server_zero, res_valid && !res.server_found, res.server_ident == 32'h0)

endmodule

`default_nettype wire
